// File: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the request and response structs, opcodes and character codes.
// No dependencies.
package tcw_pkg;

    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] attribute;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_col;
    } t_req;

    typedef struct packed {
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_col;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_rsp;

endpackage

// File: design/tcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tcw_fill.sv
// Per-row fill counts for the screen memory: cells at or beyond the count read as zero.
// Writes extend the count of their row; a scroll clears the count of the recycled row.
// No package dependencies.
module tcw_fill #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_mark,
    input  logic [$clog2(ROWS)-1:0]    i_mark_row,
    input  logic [$clog2(COLS)-1:0]    i_mark_col,
    input  logic                       i_clr,
    input  logic [$clog2(ROWS)-1:0]    i_clr_row,
    input  logic [$clog2(ROWS)-1:0]    i_rd_row,
    output logic [$clog2(COLS+1)-1:0]  o_rd_fill
);

    localparam int RW = $clog2(ROWS);
    localparam int FW = $clog2(COLS + 1);

    logic [FW-1:0] r_fill [ROWS];
    logic [FW-1:0] mark_end;

    assign mark_end = FW'(i_mark_col) + FW'(1);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ROWS; i++) begin
            if (!i_rst_n) begin
                r_fill[i] <= '0;
            end else if (i_clr && (i_clr_row == RW'(i))) begin
                r_fill[i] <= '0;
            end else if (i_mark && (i_mark_row == RW'(i)) && (mark_end > r_fill[i])) begin
                r_fill[i] <= mark_end;
            end
        end
    end

    assign o_rd_fill = r_fill[i_rd_row];

endmodule

// File: design/text_console_writer_unit.sv
// Text console writer: a ring of screen rows in one RAM plus cursor and scroll offset.
// A put runs S_PUT (TAB_WIDTH spaces for a tab) then S_EMIT; a read runs S_READ, S_RDATA,
// S_EMIT. S_EMIT waits while a response is unaccepted, then S_IDLE takes the next request.
// One screen cell is written or read per cycle through the single RAM port pair.
// Reset clears cursor, scroll offset and row fill counts at once; no clearing pass,
// the block takes requests on the first cycle after reset.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int ROWS      = 25,
    parameter int COLS      = 80,
    parameter int TAB_WIDTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int FW    = $clog2(COLS + 1);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_READ,
        S_RDATA,
        S_EMIT
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_top;
    logic [TW-1:0]     r_cnt;
    logic              r_scr;
    logic              r_hit;
    logic [CELL_W-1:0] r_cell;
    logic              r_out_valid;
    t_rsp              r_out;

    logic              is_tab;
    logic              is_cr;
    logic              is_nl;
    logic              put_wr;
    logic [CW:0]       col_inc;
    logic              wrap;
    logic              adv;
    logic              scroll;
    logic              put_done;
    logic [RW-1:0]     n_row;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_top;
    logic [RW:0]       cur_sum;
    logic [RW-1:0]     phys_cur;
    logic [RW:0]       rd_sum;
    logic [RW-1:0]     phys_rd;
    logic [CW-1:0]     rd_col;
    logic              rd_in_range;
    logic [FW-1:0]     rd_fill;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic              emit_ok;

    always_comb begin
        is_tab   = (r_req.char_code == CH_TAB);
        is_cr    = (r_req.char_code == CH_RETURN);
        is_nl    = (r_req.char_code == CH_NEWLINE);
        put_wr   = !is_cr && !is_nl;
        col_inc  = {1'b0, r_col} + (CW + 1)'(1);
        wrap     = put_wr && (32'(col_inc) >= COLS);
        adv      = is_nl || wrap;
        scroll   = adv && (r_row == LAST_ROW);
        n_col    = (is_cr || is_nl || wrap) ? '0 : col_inc[CW-1:0];
        n_row    = (adv && !scroll) ? r_row + RW'(1) : r_row;
        n_top    = (r_top == LAST_ROW) ? '0 : r_top + RW'(1);
        put_done = !is_tab || (r_cnt == TW'(TAB_WIDTH - 1));

        cur_sum  = {1'b0, r_top} + {1'b0, r_row};
        phys_cur = (32'(cur_sum) >= ROWS) ? RW'(cur_sum - (RW + 1)'(ROWS)) : RW'(cur_sum);

        rd_in_range = (32'(r_req.read_row) < ROWS) && (32'(r_req.read_col) < COLS);
        rd_col      = CW'(r_req.read_col);
        rd_sum      = {1'b0, r_top} + {1'b0, RW'(r_req.read_row)};
        phys_rd     = (32'(rd_sum) >= ROWS) ? RW'(rd_sum - (RW + 1)'(ROWS)) : RW'(rd_sum);

        ram_we    = (r_state == S_PUT) && put_wr;
        ram_waddr = AW'(phys_cur) * COLS_A + AW'(r_col);
        ram_wdata = {r_req.attribute, is_tab ? CH_SPACE : r_req.char_code};
        ram_re    = (r_state == S_READ);
        ram_raddr = AW'(phys_rd) * COLS_A + AW'(rd_col);

        emit_ok   = !r_out_valid || i_rsp_ready;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_fill #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_fill (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mark     (ram_we),
        .i_mark_row (phys_cur),
        .i_mark_col (r_col),
        .i_clr      ((r_state == S_PUT) && scroll),
        .i_clr_row  (r_top),
        .i_rd_row   (phys_rd),
        .o_rd_fill  (rd_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_rsp_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_cnt   <= '0;
                        r_scr   <= 1'b0;
                        r_cell  <= '0;
                        r_state <= (i_req.op == OP_READ) ? S_READ : S_PUT;
                    end
                end
                S_PUT: begin
                    r_col <= n_col;
                    r_row <= n_row;
                    if (scroll) begin
                        r_top <= n_top;
                        r_scr <= 1'b1;
                    end
                    r_cnt <= r_cnt + TW'(1);
                    if (put_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_READ: begin
                    r_hit   <= rd_in_range && (FW'(rd_col) < rd_fill);
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_cell  <= r_hit ? ram_rdata : '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out.cursor_row <= ROW_FW'(r_row);
                        r_out.cursor_col <= COL_FW'(r_col);
                        r_out.cell_data  <= r_cell;
                        r_out.scrolled   <= r_scr;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLS)
        else $error("cursor column out of range");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) < ROWS)
        else $error("scroll offset out of range");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) && scroll |=> (r_row == LAST_ROW) && r_scr)
        else $error("scroll did not leave cursor on last row");

    a_put_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_cell == '0))
        else $error("cell data not zero on put");

endmodule

// File: sim/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer_unit: a queue-fed driver, a stalling
// receiver and a cell-level model of the console that predicts every response.
// Depends on tcw_pkg and text_console_writer_unit.
module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int SCR_ROWS     = 25;
    localparam int SCR_COLS     = 80;
    localparam int TAB_SPACES   = 8;
    localparam int RANDOM_REQS  = 1900;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int unsigned err_count = 0;
    int unsigned rsp_count = 0;
    int unsigned idle_cycles = 0;
    bit timed_out = 1'b0;

    logic [CELL_W-1:0] shadow_screen [SCR_ROWS*SCR_COLS];
    int unsigned cur_row = 0;
    int unsigned cur_col = 0;
    int unsigned top_row = 0;

    text_console_writer_unit #(
        .ROWS(SCR_ROWS),
        .COLS(SCR_COLS),
        .TAB_WIDTH(TAB_SPACES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Moving below the last row recycles the oldest storage row as the new bottom row.
    function automatic bit line_down();
        int unsigned base;
        cur_row++;
        if (cur_row >= SCR_ROWS) begin
            base = top_row * SCR_COLS;
            for (int c = 0; c < SCR_COLS; c++) begin
                shadow_screen[base + c] = '0;
            end
            top_row = (top_row + 1) % SCR_ROWS;
            cur_row = SCR_ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit store_char(logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
        int unsigned idx;
        if (ch == CH_RETURN) begin
            cur_col = 0;
            return 1'b0;
        end
        if (ch == CH_NEWLINE) begin
            cur_col = 0;
            return line_down();
        end
        idx = ((top_row + cur_row) % SCR_ROWS) * SCR_COLS + cur_col;
        shadow_screen[idx] = {attr, ch};
        cur_col++;
        if (cur_col >= SCR_COLS) begin
            cur_col = 0;
            return line_down();
        end
        return 1'b0;
    endfunction

    function automatic t_rsp console_predict(t_req r);
        t_rsp rsp;
        int unsigned idx;
        rsp = '0;
        if (r.op == OP_PUT) begin
            if (r.char_code == CH_TAB) begin
                for (int i = 0; i < TAB_SPACES; i++) begin
                    if (store_char(CH_SPACE, r.attribute)) begin
                        rsp.scrolled = 1'b1;
                    end
                end
            end else begin
                rsp.scrolled = store_char(r.char_code, r.attribute);
            end
        end else if (r.read_row < SCR_ROWS && r.read_col < SCR_COLS) begin
            idx = ((top_row + r.read_row) % SCR_ROWS) * SCR_COLS + r.read_col;
            rsp.cell_data = shadow_screen[idx];
        end
        rsp.cursor_row = cur_row[ROW_FW-1:0];
        rsp.cursor_col = cur_col[COL_FW-1:0];
        return rsp;
    endfunction

    function automatic t_req make_put(logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
        t_req r;
        r.op = OP_PUT;
        r.char_code = ch;
        r.attribute = attr;
        r.read_row = ROW_FW'($urandom);
        r.read_col = COL_FW'($urandom);
        return r;
    endfunction

    function automatic t_req make_read(logic [ROW_FW-1:0] row, logic [COL_FW-1:0] col);
        t_req r;
        r.op = OP_READ;
        r.char_code = CHAR_W'($urandom);
        r.attribute = CHAR_W'($urandom);
        r.read_row = row;
        r.read_col = col;
        return r;
    endfunction

    function automatic t_req make_random_req();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            return make_put(CHAR_W'($urandom), CHAR_W'($urandom));
        end else if (kind < 66) begin
            return make_put(CH_NEWLINE, CHAR_W'($urandom));
        end else if (kind < 69) begin
            return make_put(CH_RETURN, CHAR_W'($urandom));
        end else if (kind < 75) begin
            return make_put(CH_TAB, CHAR_W'($urandom));
        end else if (kind < 95) begin
            return make_read(ROW_FW'($urandom_range(0, SCR_ROWS - 1)),
                             ($urandom_range(0, 9) < 7) ? COL_FW'($urandom_range(0, 31))
                                                        : COL_FW'($urandom_range(0, 79)));
        end
        return make_read(ROW_FW'($urandom), COL_FW'($urandom));
    endfunction

    // Driver: each request first waits out a random send_wait delay, except during random bursts with no gaps.
    int unsigned send_wait = 0;
    bit send_burst = 1'b0;
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            send_wait = $urandom_range(0, 15);
        end else begin
            offer = i_req_valid;
            if (i_req_valid && o_req_ready) begin
                expected_rsps.push_back(console_predict(i_req));
                offer = 1'b0;
                if ($urandom_range(0, 49) == 0) begin
                    send_burst = !send_burst;
                end
                send_wait = send_burst ? 0 : $urandom_range(0, 15);
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_reqs.size() > 0) begin
                    i_req <= pending_reqs.pop_front();
                    offer = 1'b1;
                end
            end
            i_req_valid <= offer;
        end
    end

    // Receiver: stalls for a random recv_stall delay after each response, and once for a long stretch
    // so that the block backs up and stops taking requests.
    int unsigned recv_stall = 0;
    bit recv_burst = 1'b0;
    always @(posedge i_clk) begin
        bit take;
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            recv_stall = $urandom_range(0, 15);
        end else begin
            take = i_rsp_ready;
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding");
                    err_count++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.cursor_row !== exp_rsp.cursor_row) begin
                        $error("cursor_row expected %0d got %0d",
                               exp_rsp.cursor_row, o_rsp.cursor_row);
                        err_count++;
                    end
                    if (o_rsp.cursor_col !== exp_rsp.cursor_col) begin
                        $error("cursor_col expected %0d got %0d",
                               exp_rsp.cursor_col, o_rsp.cursor_col);
                        err_count++;
                    end
                    if (o_rsp.cell_data !== exp_rsp.cell_data) begin
                        $error("cell_data expected %04h got %04h",
                               exp_rsp.cell_data, o_rsp.cell_data);
                        err_count++;
                    end
                    if (o_rsp.scrolled !== exp_rsp.scrolled) begin
                        $error("scrolled expected %0d got %0d",
                               exp_rsp.scrolled, o_rsp.scrolled);
                        err_count++;
                    end
                end
                if ($urandom_range(0, 49) == 0) begin
                    recv_burst = !recv_burst;
                end
                if (rsp_count == HOLD_AT) begin
                    recv_stall = HOLD_CYCLES;
                end else begin
                    recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
                end
                take = (recv_stall == 0);
            end else if (!i_rsp_ready) begin
                if (recv_stall > 0) begin
                    recv_stall--;
                end else begin
                    take = 1'b1;
                end
            end
            i_rsp_ready <= take;
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SCR_ROWS * SCR_COLS; i++) begin
            shadow_screen[i] = '0;
        end

        // Directed requests: field extremes, out-of-range reads, every control character.
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(0)));
        pending_reqs.push_back(make_read(ROW_FW'(SCR_ROWS - 1), COL_FW'(SCR_COLS - 1)));
        pending_reqs.push_back(make_read(ROW_FW'(SCR_ROWS), COL_FW'(0)));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(SCR_COLS)));
        pending_reqs.push_back(make_read('1, '1));
        pending_reqs.push_back(make_put(8'h41, 8'h1F));
        pending_reqs.push_back(make_put(8'h00, 8'h00));
        pending_reqs.push_back(make_put(8'hFF, 8'hFF));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(0)));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(1)));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(2)));
        pending_reqs.push_back(make_put(CH_TAB, 8'hA5));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(10)));
        pending_reqs.push_back(make_put(CH_RETURN, 8'hFF));
        pending_reqs.push_back(make_put(8'h42, 8'h5A));
        pending_reqs.push_back(make_put(CH_NEWLINE, 8'hFF));
        pending_reqs.push_back(make_put(8'h43, 8'h80));
        pending_reqs.push_back(make_read(ROW_FW'(0), COL_FW'(0)));
        pending_reqs.push_back(make_read(ROW_FW'(1), COL_FW'(0)));
        pending_reqs.push_back(make_read(ROW_FW'(1), COL_FW'(1)));

        for (int i = 0; i < RANDOM_REQS; i++) begin
            pending_reqs.push_back(make_random_req());
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                while (pending_reqs.size() != 0 || i_req_valid) @(posedge i_clk);
                while (expected_rsps.size() != 0) @(posedge i_clk);
                repeat (40) @(posedge i_clk);
            end
            begin
                while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && err_count == 0) begin
            $display("text_console_writer_unit_tb OK");
        end else begin
            $display("text_console_writer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_fill.sv
design/text_console_writer_unit.sv
sim/text_console_writer_unit_tb.sv
